@@ design/tpp_pkg.sv @@
// Shared types, codes and mode-string tables for the TFTP packet parser.
package tpp_pkg;

  typedef enum logic [2:0] {
    PH_OPHI  = 3'd0,
    PH_OPLO  = 3'd1,
    PH_NAME  = 3'd2,
    PH_MODE  = 3'd3,
    PH_NUMHI = 3'd4,
    PH_NUMLO = 3'd5,
    PH_BODY  = 3'd6,
    PH_END   = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NAME    = 2'd0,
    KIND_MESSAGE = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_SUMMARY = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_BAD_OP    = 3'd2,
    ST_BAD_MODE  = 3'd3,
    ST_MALFORMED = 3'd4,
    ST_TOO_LONG  = 3'd5
  } status_t;

  localparam logic [15:0] OP_RRQ   = 16'd1;
  localparam logic [15:0] OP_WRQ   = 16'd2;
  localparam logic [15:0] OP_DATA  = 16'd3;
  localparam logic [15:0] OP_ACK   = 16'd4;
  localparam logic [15:0] OP_ERROR = 16'd5;

  localparam logic [1:0] MODE_NETASCII = 2'd0;
  localparam logic [1:0] MODE_OCTET    = 2'd1;
  localparam logic [1:0] MODE_MAIL     = 2'd2;
  localparam logic [1:0] MODE_NONE     = 2'd3;

  localparam int unsigned NUM_MODES   = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One queue entry holds everything a single input byte produces.
  typedef struct packed {
    logic        has_content;
    kind_t       content_kind;
    logic [7:0]  content_byte;
    logic        has_summary;
    logic [15:0] opcode;
    logic [15:0] number;
    logic [1:0]  mode;
    logic [9:0]  pay_len;
    status_t     status;
  } entry_t;

  function automatic logic [3:0] mode_len(input logic [1:0] k);
    logic [3:0] len;
    case (k)
      MODE_NETASCII: len = 4'd8;
      MODE_OCTET:    len = 4'd5;
      default:       len = 4'd4;
    endcase
    return len;
  endfunction

  // Character idx of mode string k; the first character sits in the top byte.
  function automatic logic [7:0] mode_char(input logic [1:0] k, input logic [2:0] idx);
    logic [63:0] txt;
    case (k)
      MODE_NETASCII: txt = "netascii";
      MODE_OCTET:    txt = {"octet", 24'h0};
      default:       txt = {"mail", 32'h0};
    endcase
    return txt[{3'(3'd7 - idx), 3'b000} +: 8];
  endfunction

endpackage

@@ design/tftp_packet_parser.sv @@
// TFTP packet parser: byte-serial front end, entry queue and output stage.
//
// Usage: packet bytes enter on the in_ channel, one item per byte, first byte
// first, with in_last_byte high on the final byte. Each filename, error
// message or DATA payload byte comes out as one out_ item (the terminating
// zero is not passed). The final byte also yields a summary item with
// out_kind = summary and out_end_of_run high, carrying opcode, block number or
// error code, transfer mode, payload length and status.
// Throughput: one byte per cycle while in_stall is low. The front end handles
// every byte as it is accepted; the final byte of a packet may produce two
// items, which the output stage sends one after the other while the
// four-entry queue absorbs the extra one.
// Path: each accepted byte's entry is written into the queue and then into the
// output register, from which it is driven on out_.
// Stall: when out_stall holds the output register, the queue fills and
// in_stall rises once it holds four entries; nothing is lost.
// Reset: synchronous on rst_n low; the queue empties, the output goes invalid
// and the parser waits for the first opcode byte of a new packet.
module tftp_packet_parser import tpp_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = 516
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_packet_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_content_byte,
  output logic [15:0] out_opcode_seen,
  output logic [15:0] out_block_or_code,
  output logic [1:0]  out_transfer_mode,
  output logic [9:0]  out_payload_length,
  output logic [2:0]  out_status,
  output logic        out_end_of_run
);

  logic   push;
  entry_t push_entry;
  logic   pop;
  entry_t head;
  logic   q_valid;
  logic   q_full;

  tpp_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_packet_byte(in_packet_byte),
    .in_last_byte  (in_last_byte),
    .q_full        (q_full),
    .push          (push),
    .push_entry    (push_entry)
  );

  tpp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .q_valid   (q_valid),
    .q_full    (q_full)
  );

  tpp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_content_byte  (out_content_byte),
    .out_opcode_seen   (out_opcode_seen),
    .out_block_or_code (out_block_or_code),
    .out_transfer_mode (out_transfer_mode),
    .out_payload_length(out_payload_length),
    .out_status        (out_status),
    .out_end_of_run    (out_end_of_run)
  );

endmodule

@@ design/tpp_front.sv @@
// Front end: accepts packet bytes, tracks the field layout and builds queue entries.
module tpp_front import tpp_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = 516
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_packet_byte,
  input  logic       in_last_byte,
  input  logic       q_full,
  output logic       push,
  output entry_t     push_entry
);

  localparam logic [9:0] POS_LIMIT = 10'(MAX_PACKET_BYTES);

  logic [9:0]  pos_r, pos_nxt;
  phase_t      phase_r, phase_nxt;
  logic [15:0] opcode_r, opcode_nxt;
  logic [15:0] number_r, number_nxt;
  logic [3:0]  mode_idx_r, mode_idx_nxt;
  logic [2:0]  mode_flags_r, mode_flags_nxt;
  logic [9:0]  pay_cnt_r, pay_cnt_nxt;
  status_t     err_r, err_nxt;

  logic        accept;
  logic [2:0]  hit;
  status_t     sum_status;
  entry_t      ent;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    pos_nxt        = pos_r;
    phase_nxt      = phase_r;
    opcode_nxt     = opcode_r;
    number_nxt     = number_r;
    mode_idx_nxt   = mode_idx_r;
    mode_flags_nxt = mode_flags_r;
    pay_cnt_nxt    = pay_cnt_r;
    err_nxt        = err_r;
    hit            = '0;
    sum_status     = ST_OK;
    ent            = '0;
    ent.mode       = MODE_NONE;
    ent.status     = ST_OK;

    if (err_nxt == ST_OK && pos_r >= POS_LIMIT) begin
      err_nxt = ST_TOO_LONG;
    end

    if (err_nxt == ST_OK) begin
      case (phase_r)
        PH_OPHI: begin
          opcode_nxt = {in_packet_byte, 8'h00};
          phase_nxt  = PH_OPLO;
        end
        PH_OPLO: begin
          opcode_nxt = {opcode_r[15:8], in_packet_byte};
          if (opcode_nxt == OP_RRQ || opcode_nxt == OP_WRQ) begin
            phase_nxt = PH_NAME;
          end else if (opcode_nxt >= OP_DATA && opcode_nxt <= OP_ERROR) begin
            phase_nxt = PH_NUMHI;
          end else begin
            err_nxt = ST_BAD_OP;
          end
        end
        PH_NAME: begin
          if (in_packet_byte == 8'h00) begin
            phase_nxt = PH_MODE;
          end else begin
            ent.has_content  = 1'b1;
            ent.content_kind = KIND_NAME;
            ent.content_byte = in_packet_byte;
          end
        end
        PH_MODE: begin
          if (in_packet_byte == 8'h00) begin
            for (int k = 0; k < NUM_MODES; k++) begin
              hit[k] = mode_flags_r[k] && (mode_idx_r == mode_len(2'(k)));
            end
            if (hit == 3'b000) begin
              err_nxt = ST_BAD_MODE;
            end
            mode_flags_nxt = hit;
            phase_nxt      = PH_END;
          end else begin
            for (int k = 0; k < NUM_MODES; k++) begin
              if (mode_idx_r >= mode_len(2'(k)) ||
                  mode_char(2'(k), mode_idx_r[2:0]) != in_packet_byte) begin
                mode_flags_nxt[k] = 1'b0;
              end
            end
            if (mode_idx_r != 4'hF) begin
              mode_idx_nxt = mode_idx_r + 4'd1;
            end
          end
        end
        PH_NUMHI: begin
          number_nxt = {in_packet_byte, 8'h00};
          phase_nxt  = PH_NUMLO;
        end
        PH_NUMLO: begin
          number_nxt = {number_r[15:8], in_packet_byte};
          phase_nxt  = (opcode_r == OP_ACK) ? PH_END : PH_BODY;
        end
        PH_BODY: begin
          if (opcode_r == OP_DATA) begin
            ent.has_content  = 1'b1;
            ent.content_kind = KIND_PAYLOAD;
            ent.content_byte = in_packet_byte;
            if (pay_cnt_r != 10'h3FF) begin
              pay_cnt_nxt = pay_cnt_r + 10'd1;
            end
          end else if (in_packet_byte == 8'h00) begin
            phase_nxt = PH_END;
          end else begin
            ent.has_content  = 1'b1;
            ent.content_kind = KIND_MESSAGE;
            ent.content_byte = in_packet_byte;
          end
        end
        default: begin
          // Any byte after a complete packet is trailing garbage.
          err_nxt = ST_MALFORMED;
        end
      endcase
    end

    if (pos_r != 10'h3FF) begin
      pos_nxt = pos_r + 10'd1;
    end

    if (in_last_byte) begin
      sum_status = err_nxt;
      if (sum_status == ST_OK) begin
        if (phase_nxt == PH_OPHI || phase_nxt == PH_OPLO ||
            phase_nxt == PH_NUMHI || phase_nxt == PH_NUMLO) begin
          sum_status = ST_TOO_SHORT;
        end else if (phase_nxt == PH_NAME || phase_nxt == PH_MODE ||
                     (phase_nxt == PH_BODY && opcode_nxt != OP_DATA)) begin
          sum_status = ST_MALFORMED;
        end
      end
      ent.has_summary = 1'b1;
      ent.opcode      = opcode_nxt;
      ent.status      = sum_status;
      if (opcode_nxt >= OP_DATA && opcode_nxt <= OP_ERROR) begin
        ent.number = number_nxt;
      end
      if (opcode_nxt == OP_DATA) begin
        ent.pay_len = pay_cnt_nxt;
      end
      if (sum_status == ST_OK && (opcode_nxt == OP_RRQ || opcode_nxt == OP_WRQ)) begin
        if (mode_flags_nxt[0]) begin
          ent.mode = MODE_NETASCII;
        end else if (mode_flags_nxt[1]) begin
          ent.mode = MODE_OCTET;
        end else if (mode_flags_nxt[2]) begin
          ent.mode = MODE_MAIL;
        end
      end
      // The parser starts over for the next packet.
      pos_nxt        = '0;
      phase_nxt      = PH_OPHI;
      opcode_nxt     = '0;
      number_nxt     = '0;
      mode_idx_nxt   = '0;
      mode_flags_nxt = '1;
      pay_cnt_nxt    = '0;
      err_nxt        = ST_OK;
    end
  end

  assign push       = accept && (ent.has_content || ent.has_summary);
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      phase_r      <= PH_OPHI;
      opcode_r     <= '0;
      number_r     <= '0;
      mode_idx_r   <= '0;
      mode_flags_r <= '1;
      pay_cnt_r    <= '0;
      err_r        <= ST_OK;
    end else if (accept) begin
      pos_r        <= pos_nxt;
      phase_r      <= phase_nxt;
      opcode_r     <= opcode_nxt;
      number_r     <= number_nxt;
      mode_idx_r   <= mode_idx_nxt;
      mode_flags_r <= mode_flags_nxt;
      pay_cnt_r    <= pay_cnt_nxt;
      err_r        <= err_nxt;
    end
  end

endmodule

@@ design/tpp_queue.sv @@
// Small register FIFO that decouples the parsing front end from the output stage.
module tpp_queue import tpp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   q_valid,
  output logic   q_full
);

  entry_t              slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign head    = slots_r[rd_ptr_r];
  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == QCNT_W'(QUEUE_DEPTH));

  // Pointers wrap on their own since the depth is a power of two.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ design/tpp_back.sv @@
// Output stage: unpacks queue entries into one result item per cycle unless out_stall holds it.
module tpp_back import tpp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  entry_t      head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_content_byte,
  output logic [15:0] out_opcode_seen,
  output logic [15:0] out_block_or_code,
  output logic [1:0]  out_transfer_mode,
  output logic [9:0]  out_payload_length,
  output logic [2:0]  out_status,
  output logic        out_end_of_run
);

  logic        valid_r, valid_nxt;
  logic        done_r, done_nxt;
  kind_t       kind_r;
  logic [7:0]  byte_r;
  logic [15:0] opcode_r;
  logic [15:0] number_r;
  logic [1:0]  mode_r;
  logic [9:0]  len_r;
  status_t     status_r;
  logic        eor_r;

  logic        load;
  logic        emit_content;
  logic        emit_summary;

  assign load = !valid_r || !out_stall;

  // An entry with both a content byte and a summary yields two items in turn;
  // done_r records that its content item already went out.
  always_comb begin
    pop          = 1'b0;
    emit_content = 1'b0;
    emit_summary = 1'b0;
    done_nxt     = done_r;
    valid_nxt    = valid_r;
    if (load) begin
      valid_nxt = q_valid;
      if (q_valid) begin
        if (head.has_content && !done_r) begin
          emit_content = 1'b1;
          if (head.has_summary) begin
            done_nxt = 1'b1;
          end else begin
            pop = 1'b1;
          end
        end else begin
          emit_summary = 1'b1;
          pop          = 1'b1;
          done_nxt     = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_content) begin
      kind_r   <= head.content_kind;
      byte_r   <= head.content_byte;
      opcode_r <= '0;
      number_r <= '0;
      mode_r   <= MODE_NONE;
      len_r    <= '0;
      status_r <= ST_OK;
      eor_r    <= 1'b0;
    end else if (emit_summary) begin
      kind_r   <= KIND_SUMMARY;
      byte_r   <= '0;
      opcode_r <= head.opcode;
      number_r <= head.number;
      mode_r   <= head.mode;
      len_r    <= head.pay_len;
      status_r <= head.status;
      eor_r    <= 1'b1;
    end
  end

  assign out_valid          = valid_r;
  assign out_kind           = kind_r;
  assign out_content_byte   = byte_r;
  assign out_opcode_seen    = opcode_r;
  assign out_block_or_code  = number_r;
  assign out_transfer_mode  = mode_r;
  assign out_payload_length = len_r;
  assign out_status         = status_r;
  assign out_end_of_run     = eor_r;

endmodule

@@ design/tpp_checker.sv @@
// Port-level checks for the TFTP packet parser, bound to the top level.
module tpp_checker import tpp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_packet_byte,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_content_byte,
  input logic [15:0] out_opcode_seen,
  input logic [15:0] out_block_or_code,
  input logic [1:0]  out_transfer_mode,
  input logic [9:0]  out_payload_length,
  input logic [2:0]  out_status,
  input logic        out_end_of_run
);

  // The output register is empty right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // Only a summary closes a packet, and every summary does.
  a_eor_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_end_of_run == (out_kind == KIND_SUMMARY)))
    else $error("end_of_run does not match the summary kind");

  // A transfer mode is reported only in an ok summary.
  a_mode_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_transfer_mode != MODE_NONE |->
      out_kind == KIND_SUMMARY && out_status == ST_OK)
    else $error("transfer mode outside an ok summary");

  // A stalled input item is held by the sender.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=>
      in_valid && $stable(in_packet_byte) && $stable(in_last_byte))
    else $error("stalled input item changed");

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_kind) && $stable(out_content_byte) &&
      $stable(out_status) && $stable(out_opcode_seen) &&
      $stable(out_block_or_code) && $stable(out_transfer_mode) &&
      $stable(out_payload_length) && $stable(out_end_of_run))
    else $error("stalled result item changed");

endmodule

bind tftp_packet_parser tpp_checker u_tpp_checker (.*);
